@@ src/orff_pkg.sv @@
// Shared types, constants and the codon classifier for the open reading frame finder.
// No dependencies; every other file in src imports this package.
package orff_pkg;

    localparam int INDEX_WIDTH_DEF = 16;
    localparam int FIELD_W         = 16;
    localparam int CFG_W           = 16;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [FIELD_W-1:0] MIN_CODONS_RST = 16'd30;

    // Configuration register indexes.
    localparam logic REG_MIN_CODONS = 1'b0;
    localparam logic REG_CIRCULAR   = 1'b1;

    // Base encoding.
    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    typedef enum logic [1:0] {
        CLS_OTHER,
        CLS_MET,
        CLS_STOP
    } t_codon_class;

    // Control flags of one queued job.
    typedef struct packed {
        logic close_v;   // stop closed an open Met
        logic last;      // final codon of the sequence
        logic no_stop;   // sequence had no stop
        logic ns_met;    // no-stop ORF begins at a Met
        logic wrap_v;    // circular wrap candidate exists
        logic endless;   // circular mode copy for the no-stop ORF
    } t_job_flags;

    // One result beat.
    typedef struct packed {
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic               has_stop;
        logic               has_met;
        logic               endless;
        logic               run_end;
    } t_orf;

    function automatic t_codon_class classify(input logic [1:0] b1,
                                              input logic [1:0] b2,
                                              input logic [1:0] b3);
        t_codon_class cls;
        cls = CLS_OTHER;
        if (b1 == BASE_A && b2 == BASE_T && b3 == BASE_G) begin
            cls = CLS_MET;
        end else if (b1 == BASE_T &&
                     ((b2 == BASE_A && (b3 == BASE_A || b3 == BASE_G)) ||
                      (b2 == BASE_G && b3 == BASE_A))) begin
            cls = CLS_STOP;
        end
        return cls;
    endfunction

endpackage

@@ src/orff_front.sv @@
// Front end: classifies each accepted codon, tracks Met and stop positions and
// builds one job per codon for the back end. Depends on orff_pkg.
module orff_front import orff_pkg::*; #(
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [1:0]             i_base_first,
    input  logic [1:0]             i_base_second,
    input  logic [1:0]             i_base_third,
    input  logic                   i_last_codon,
    input  logic                   i_circular,
    output t_job_flags             o_flags,
    output logic [INDEX_WIDTH-1:0] o_close_start,
    output logic [INDEX_WIDTH-1:0] o_close_len,
    output logic [INDEX_WIDTH-1:0] o_end_start,
    output logic [INDEX_WIDTH-1:0] o_ns_len,
    output logic [INDEX_WIDTH-1:0] o_wrap_stop,
    output logic [INDEX_WIDTH-1:0] o_count
);

    localparam logic [INDEX_WIDTH-1:0] IDX_MAX = '1;

    logic [INDEX_WIDTH-1:0] r_idx, n_idx;
    logic [INDEX_WIDTH-1:0] r_ms, n_ms;
    logic                   r_ms_v, n_ms_v;
    logic [INDEX_WIDTH-1:0] r_ml, n_ml;
    logic                   r_ml_v, n_ml_v;
    logic [INDEX_WIDTH-1:0] r_fs, n_fs;
    logic                   r_fs_v, n_fs_v;
    logic [INDEX_WIDTH-1:0] r_fm, n_fm;
    logic                   r_fm_v, n_fm_v;

    t_codon_class           cls;
    logic [INDEX_WIDTH-1:0] count;
    logic [INDEX_WIDTH-1:0] ns_start;

    always_comb begin
        cls    = classify(i_base_first, i_base_second, i_base_third);
        n_ms   = r_ms;
        n_ms_v = r_ms_v;
        n_ml   = r_ml;
        n_ml_v = r_ml_v;
        n_fs   = r_fs;
        n_fs_v = r_fs_v;
        n_fm   = r_fm;
        n_fm_v = r_fm_v;
        case (cls)
            CLS_MET: begin
                if (!r_ms_v) begin
                    n_ms   = r_idx;
                    n_ms_v = 1'b1;
                end
                n_ml   = r_idx;
                n_ml_v = 1'b1;
                if (!r_fm_v) begin
                    n_fm   = r_idx;
                    n_fm_v = 1'b1;
                end
            end
            CLS_STOP: begin
                if (!r_fs_v) begin
                    n_fs   = r_idx;
                    n_fs_v = 1'b1;
                end
                n_ms_v = 1'b0;
                n_ml_v = 1'b0;
            end
            default: begin
            end
        endcase

        // The codon count saturates with the index.
        count    = (r_idx == IDX_MAX) ? IDX_MAX : r_idx + 1'b1;
        ns_start = n_fm_v ? n_fm : '0;

        o_flags.close_v = (cls == CLS_STOP) && r_ms_v;
        o_flags.last    = i_last_codon;
        o_flags.no_stop = !n_fs_v;
        o_flags.ns_met  = n_fm_v;
        o_flags.wrap_v  = i_circular && n_ml_v;
        o_flags.endless = i_circular;

        o_close_start = r_ms;
        o_close_len   = r_idx - r_ms;
        o_end_start   = n_fs_v ? n_ml : ns_start;
        o_ns_len      = count - ns_start;
        o_wrap_stop   = n_fs;
        o_count       = count;

        n_idx = r_idx;
        if (i_last_codon) begin
            n_idx  = '0;
            n_ms_v = 1'b0;
            n_ml_v = 1'b0;
            n_fs_v = 1'b0;
            n_fm_v = 1'b0;
        end else if (r_idx != IDX_MAX) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_ms_v <= 1'b0;
            r_ml_v <= 1'b0;
            r_fs_v <= 1'b0;
            r_fm_v <= 1'b0;
        end else if (i_accept) begin
            r_idx  <= n_idx;
            r_ms_v <= n_ms_v;
            r_ml_v <= n_ml_v;
            r_fs_v <= n_fs_v;
            r_fm_v <= n_fm_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_ms <= n_ms;
            r_ml <= n_ml;
            r_fs <= n_fs;
            r_fm <= n_fm;
        end
    end

endmodule

@@ src/orff_queue.sv @@
// Small register queue that decouples the front end from the back end.
// Depends on orff_pkg for the default depth.
module orff_queue import orff_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [PW:0]      r_cnt;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == (PW + 1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (i_rd) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_rd && !i_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ src/orff_back.sv @@
// Back end: takes jobs from the queue, filters ORFs by length and presents up
// to two result beats per job on a two-slot output stage. Depends on orff_pkg.
module orff_back import orff_pkg::*; #(
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_empty,
    input  t_job_flags             i_flags,
    input  logic [INDEX_WIDTH-1:0] i_close_start,
    input  logic [INDEX_WIDTH-1:0] i_close_len,
    input  logic [INDEX_WIDTH-1:0] i_end_start,
    input  logic [INDEX_WIDTH-1:0] i_ns_len,
    input  logic [INDEX_WIDTH-1:0] i_wrap_stop,
    input  logic [INDEX_WIDTH-1:0] i_count,
    input  logic [FIELD_W-1:0]     i_min_codons,
    output logic                   o_q_pop,
    input  logic                   i_pop,
    output logic                   o_empty,
    output t_orf                   o_orf
);

    localparam int CW = (INDEX_WIDTH > FIELD_W) ? INDEX_WIDTH : FIELD_W;
    localparam logic [INDEX_WIDTH-1:0] IDX_MAX = '1;

    logic                   r_a_v, r_b_v;
    t_orf                   r_a, r_b;
    t_orf                   a_res, b_res;
    logic                   a_ok, b_ok;
    logic [INDEX_WIDTH:0]   wrap_sum;
    logic [INDEX_WIDTH-1:0] wrap_len;
    logic [INDEX_WIDTH-1:0] end_len;
    logic                   pop_ok, load, slots_free;

    always_comb begin
        wrap_sum = {1'b0, i_wrap_stop} + {1'b0, i_count} - {1'b0, i_end_start};
        wrap_len = wrap_sum[INDEX_WIDTH] ? IDX_MAX : wrap_sum[INDEX_WIDTH-1:0];
        end_len  = i_flags.no_stop ? i_ns_len : wrap_len;

        a_ok = i_flags.close_v && (CW'(i_close_len) >= CW'(i_min_codons));
        // The no-stop ORF ignores the minimum length.
        b_ok = i_flags.last &&
               (i_flags.no_stop ||
                (i_flags.wrap_v && (CW'(wrap_len) >= CW'(i_min_codons))));

        a_res.start    = FIELD_W'(i_close_start);
        a_res.length   = FIELD_W'(i_close_len);
        a_res.has_stop = 1'b1;
        a_res.has_met  = 1'b1;
        a_res.endless  = 1'b0;
        a_res.run_end  = !b_ok;

        b_res.start    = FIELD_W'(i_end_start);
        b_res.length   = FIELD_W'(end_len);
        b_res.has_stop = !i_flags.no_stop;
        b_res.has_met  = i_flags.no_stop ? i_flags.ns_met : 1'b1;
        b_res.endless  = i_flags.no_stop && i_flags.endless;
        b_res.run_end  = 1'b1;
    end

    assign o_empty    = !(r_a_v || r_b_v);
    assign o_orf      = r_a_v ? r_a : r_b;
    assign pop_ok     = i_pop && !o_empty;
    // The stage can take a new job once at most one beat is left and it leaves now.
    assign slots_free = o_empty || (pop_ok && (r_a_v != r_b_v));
    assign load       = slots_free && !i_q_empty;
    assign o_q_pop    = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else if (load) begin
            r_a_v <= a_ok;
            r_b_v <= b_ok;
        end else if (pop_ok) begin
            if (r_a_v) begin
                r_a_v <= 1'b0;
            end else begin
                r_b_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_a <= a_res;
            r_b <= b_res;
        end
    end

    a_run_end_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_v && r_a.run_end) |-> !r_b_v)
        else $error("first slot marks run end while second slot holds a beat");

    a_b_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_v |-> r_b.run_end)
        else $error("second slot beat does not close its run");

    a_drain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_ok && ($countones({r_a_v, r_b_v}) == 1) && i_q_empty) |=> o_empty)
        else $error("output stage not empty after its last beat left");

    a_endless_no_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_orf.endless) |-> (!o_orf.has_stop && o_orf.run_end))
        else $error("endless ORF carries a stop or is not last of its run");

endmodule

@@ src/open_reading_frame_finder_unit.sv @@
// Open reading frame finder: one codon per beat, up to two ORF beats per codon.
// Throughput: one codon per cycle while full is low; a codon with two results holds the
// output stage until both beats pop. Jobs pass the queue, then the output stage registers.
// Reset (synchronous, active low) clears the sequence state, the job queue and the output
// stage, and sets min_codons to 30 and circular to 0. Depends on orff_pkg and the submodules.
module open_reading_frame_finder_unit import orff_pkg::*; #(
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_base_first,
    input  logic [1:0]         i_base_second,
    input  logic [1:0]         i_base_third,
    input  logic               i_last_codon,
    output logic               empty,
    input  logic               pop,
    output logic [FIELD_W-1:0] o_orf_start,
    output logic [FIELD_W-1:0] o_orf_length,
    output logic               o_has_stop,
    output logic               o_has_met,
    output logic               o_endless,
    output logic               o_run_end
);

    localparam int FLAGS_W = $bits(t_job_flags);
    localparam int JOB_W   = FLAGS_W + 6 * INDEX_WIDTH;

    logic [FIELD_W-1:0]     r_min_codons;
    logic                   r_circular;
    logic                   accept;
    t_job_flags             f_flags, q_flags;
    logic [INDEX_WIDTH-1:0] f_close_start, f_close_len, f_end_start;
    logic [INDEX_WIDTH-1:0] f_ns_len, f_wrap_stop, f_count;
    logic [INDEX_WIDTH-1:0] q_close_start, q_close_len, q_end_start;
    logic [INDEX_WIDTH-1:0] q_ns_len, q_wrap_stop, q_count;
    logic [JOB_W-1:0]       q_in, q_out;
    logic                   q_empty, q_pop;
    t_orf                   orf;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_codons <= MIN_CODONS_RST;
            r_circular   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MIN_CODONS: r_min_codons <= i_cfg_data;
                REG_CIRCULAR:   r_circular   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign accept = push && !full;

    orff_front #(.INDEX_WIDTH(INDEX_WIDTH)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_base_first  (i_base_first),
        .i_base_second (i_base_second),
        .i_base_third  (i_base_third),
        .i_last_codon  (i_last_codon),
        .i_circular    (r_circular),
        .o_flags       (f_flags),
        .o_close_start (f_close_start),
        .o_close_len   (f_close_len),
        .o_end_start   (f_end_start),
        .o_ns_len      (f_ns_len),
        .o_wrap_stop   (f_wrap_stop),
        .o_count       (f_count)
    );

    assign q_in = {f_flags, f_close_start, f_close_len, f_end_start,
                   f_ns_len, f_wrap_stop, f_count};

    orff_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_data  (q_in),
        .i_rd    (q_pop),
        .o_data  (q_out),
        .o_full  (full),
        .o_empty (q_empty)
    );

    assign {q_flags, q_close_start, q_close_len, q_end_start,
            q_ns_len, q_wrap_stop, q_count} = q_out;

    orff_back #(.INDEX_WIDTH(INDEX_WIDTH)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_flags       (q_flags),
        .i_close_start (q_close_start),
        .i_close_len   (q_close_len),
        .i_end_start   (q_end_start),
        .i_ns_len      (q_ns_len),
        .i_wrap_stop   (q_wrap_stop),
        .i_count       (q_count),
        .i_min_codons  (r_min_codons),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_orf         (orf)
    );

    assign o_orf_start  = orf.start;
    assign o_orf_length = orf.length;
    assign o_has_stop   = orf.has_stop;
    assign o_has_met    = orf.has_met;
    assign o_endless    = orf.endless;
    assign o_run_end    = orf.run_end;

endmodule

@@ tb/open_reading_frame_finder_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for open_reading_frame_finder_unit: a class tracks the ORF state
// per accepted codon beat and checks each result beat. Depends on orff_pkg and the RTL.
module open_reading_frame_finder_unit_tb import orff_pkg::*;;

    localparam int IDX_MAX        = 65535;
    localparam int HOLD_CYCLES    = 300;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int LONG_FILL      = 60;

    class orf_tracker;
        logic [15:0] min_codons;
        logic        circular;
        int          codon_idx;
        int          met_open;
        int          met_latest;
        int          stop_first;
        int          met_first;
        bit          met_open_v;
        bit          met_latest_v;
        bit          stop_seen_v;
        bit          met_seen_v;
        t_orf        expected_orfs[$];
        int          errors;

        function new();
            min_codons = MIN_CODONS_RST;
            circular   = 1'b0;
            errors     = 0;
            clear_sequence();
        endfunction

        function void clear_sequence();
            codon_idx    = 0;
            met_open_v   = 0;
            met_latest_v = 0;
            stop_seen_v  = 0;
            met_seen_v   = 0;
        endfunction

        function void write_reg(logic idx, logic [15:0] value);
            if (idx == REG_MIN_CODONS) begin
                min_codons = value;
            end else begin
                circular = value[0];
            end
        endfunction

        function t_codon_class codon_kind(logic [1:0] b1, logic [1:0] b2, logic [1:0] b3);
            if (b1 == BASE_A && b2 == BASE_T && b3 == BASE_G) begin
                return CLS_MET;
            end
            if (b1 == BASE_T && b2 == BASE_A && (b3 == BASE_A || b3 == BASE_G)) begin
                return CLS_STOP;
            end
            if (b1 == BASE_T && b2 == BASE_G && b3 == BASE_A) begin
                return CLS_STOP;
            end
            return CLS_OTHER;
        endfunction

        function t_orf make_orf(int start, int len, bit stop, bit met, bit endl);
            t_orf r;
            r.start    = start[15:0];
            r.length   = (len > IDX_MAX) ? 16'hFFFF : len[15:0];
            r.has_stop = stop;
            r.has_met  = met;
            r.endless  = endl;
            r.run_end  = 1'b0;
            return r;
        endfunction

        // Works out the ORF beats that one accepted codon produces.
        function void note_codon(logic [1:0] b1, logic [1:0] b2, logic [1:0] b3, logic last);
            t_orf         made[2];
            int           n;
            int           idx;
            int           len;
            int           count;
            int           start;
            t_codon_class kind;
            n    = 0;
            idx  = codon_idx;
            kind = codon_kind(b1, b2, b3);
            if (kind == CLS_MET) begin
                if (!met_open_v) begin
                    met_open   = idx;
                    met_open_v = 1;
                end
                met_latest   = idx;
                met_latest_v = 1;
                if (!met_seen_v) begin
                    met_first  = idx;
                    met_seen_v = 1;
                end
            end else if (kind == CLS_STOP) begin
                if (!stop_seen_v) begin
                    stop_first  = idx;
                    stop_seen_v = 1;
                end
                if (met_open_v) begin
                    len = idx - met_open;
                    if (len >= int'(min_codons)) begin
                        made[n] = make_orf(met_open, len, 1, 1, 0);
                        n++;
                    end
                end
                met_open_v   = 0;
                met_latest_v = 0;
            end
            if (last) begin
                count = (idx + 1 > IDX_MAX) ? IDX_MAX : idx + 1;
                if (!stop_seen_v) begin
                    start   = met_seen_v ? met_first : 0;
                    made[n] = make_orf(start, count - start, 0, met_seen_v, circular);
                    n++;
                end else if (circular && met_latest_v) begin
                    // Wrap ORF runs past the end into the first stop of the sequence.
                    len = stop_first + count - met_latest;
                    if (len > IDX_MAX) begin
                        len = IDX_MAX;
                    end
                    if (len >= int'(min_codons)) begin
                        made[n] = make_orf(met_latest, len, 1, 1, 0);
                        n++;
                    end
                end
                clear_sequence();
            end else if (codon_idx < IDX_MAX) begin
                codon_idx++;
            end
            for (int k = 0; k < n; k++) begin
                if (k == n - 1) begin
                    made[k].run_end = 1'b1;
                end
                expected_orfs = {expected_orfs, made[k]};
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_orf(t_orf got);
            t_orf want;
            if (expected_orfs.size() == 0) begin
                $error("unexpected ORF beat: start %0d, length %0d", got.start, got.length);
                errors++;
                return;
            end
            want = expected_orfs.pop_front();
            compare_field("orf_start", want.start, got.start);
            compare_field("orf_length", want.length, got.length);
            compare_field("has_stop", want.has_stop, got.has_stop);
            compare_field("has_met", want.has_met, got.has_met);
            compare_field("endless", want.endless, got.endless);
            compare_field("run_end", want.run_end, got.run_end);
        endfunction

        function int pending();
            return expected_orfs.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index = 1'b0;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               push = 1'b0;
    logic               full;
    logic [1:0]         i_base_first = 2'd0;
    logic [1:0]         i_base_second = 2'd0;
    logic [1:0]         i_base_third = 2'd0;
    logic               i_last_codon = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic [FIELD_W-1:0] o_orf_start;
    logic [FIELD_W-1:0] o_orf_length;
    logic               o_has_stop;
    logic               o_has_met;
    logic               o_endless;
    logic               o_run_end;

    bit         send_gaps = 1'b0;
    bit         recv_gaps = 1'b0;
    bit         hold_req = 1'b0;
    orf_tracker orfs = new();

    open_reading_frame_finder_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_base_first  (i_base_first),
        .i_base_second (i_base_second),
        .i_base_third  (i_base_third),
        .i_last_codon  (i_last_codon),
        .empty         (empty),
        .pop           (pop),
        .o_orf_start   (o_orf_start),
        .o_orf_length  (o_orf_length),
        .o_has_stop    (o_has_stop),
        .o_has_met     (o_has_met),
        .o_endless     (o_endless),
        .o_run_end     (o_run_end)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // All tasks are entered right after a rising edge.
    // A write drops i_cfg_valid before it returns, so back-to-back writes never overlap.
    task automatic write_reg(logic idx, logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        orfs.write_reg(idx, value);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Leaves push high so that back-to-back beats need no gap.
    task automatic send_codon(logic [1:0] b1, logic [1:0] b2, logic [1:0] b3, logic last);
        push          <= 1'b1;
        i_base_first  <= b1;
        i_base_second <= b2;
        i_base_third  <= b3;
        i_last_codon  <= last;
        do @(posedge i_clk); while (full !== 1'b0);
        orfs.note_codon(b1, b2, b3, last);
    endtask

    task automatic maybe_pause();
        if (send_gaps && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    // Waits until every expected ORF has been popped, then idles for codons still in flight.
    task automatic settle();
        push <= 1'b0;
        @(posedge i_clk);
        while (orfs.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // One sequence; mostly Met and stop rich, sometimes plain noise with stray last marks.
    task automatic send_run(int len, bit noisy);
        logic [5:0] bases;
        logic       last;
        int         pick;
        for (int k = 0; k < len; k++) begin
            bases = 6'($urandom);
            last  = (k == len - 1);
            pick  = $urandom_range(0, 99);
            if (noisy) begin
                last = last || ($urandom_range(0, 24) == 0);
            end else if (pick < 10) begin
                bases = {BASE_A, BASE_T, BASE_G};
            end else if (pick < 13) begin
                bases = {BASE_T, BASE_A, BASE_A};
            end else if (pick < 16) begin
                bases = {BASE_T, BASE_A, BASE_G};
            end else if (pick < 19) begin
                bases = {BASE_T, BASE_G, BASE_A};
            end
            send_codon(bases[5:4], bases[3:2], bases[1:0], last);
            maybe_pause();
        end
    endtask

    initial begin
        t_orf got;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                // Long hold-off so the job queue fills and full rises.
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                @(posedge i_clk);
                if (empty === 1'b0) begin
                    got.start    = o_orf_start;
                    got.length   = o_orf_length;
                    got.has_stop = o_has_stop;
                    got.has_met  = o_has_met;
                    got.endless  = o_endless;
                    got.run_end  = o_run_end;
                    orfs.check_orf(got);
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * 20);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int sent;
        int len;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Register reset values: a linear sequence without stop, then a short closed Met.
        send_codon(BASE_A, BASE_A, BASE_A, 1'b0);
        send_codon(BASE_A, BASE_T, BASE_G, 1'b0);
        send_codon(BASE_G, BASE_G, BASE_G, 1'b1);
        send_codon(BASE_A, BASE_T, BASE_G, 1'b0);
        send_codon(BASE_T, BASE_A, BASE_A, 1'b0);
        send_codon(BASE_T, BASE_T, BASE_T, 1'b1);
        settle();

        // Circular, no length limit: closed ORF and wrap ORF, then endless sequences.
        write_reg(REG_MIN_CODONS, 16'd0);
        write_reg(REG_CIRCULAR, 16'd1);
        send_codon(BASE_T, BASE_A, BASE_G, 1'b0);
        send_codon(BASE_A, BASE_T, BASE_G, 1'b0);
        send_codon(BASE_A, BASE_T, BASE_G, 1'b0);
        send_codon(BASE_T, BASE_G, BASE_A, 1'b0);
        send_codon(BASE_A, BASE_T, BASE_G, 1'b0);
        send_codon(BASE_C, BASE_C, BASE_C, 1'b1);
        send_codon(BASE_A, BASE_T, BASE_G, 1'b1);
        send_codon(BASE_G, BASE_G, BASE_G, 1'b0);
        send_codon(BASE_C, BASE_C, BASE_C, 1'b1);
        settle();

        // Linear with a Met still open at the end gives nothing.
        write_reg(REG_CIRCULAR, 16'd0);
        send_codon(BASE_T, BASE_A, BASE_A, 1'b0);
        send_codon(BASE_A, BASE_T, BASE_G, 1'b0);
        send_codon(BASE_A, BASE_A, BASE_A, 1'b1);
        settle();

        // Largest minimum: only the no-stop ORF gets through.
        write_reg(REG_MIN_CODONS, 16'hFFFF);
        write_reg(REG_CIRCULAR, 16'd1);
        send_codon(BASE_A, BASE_T, BASE_G, 1'b0);
        send_codon(BASE_C, BASE_C, BASE_C, 1'b1);
        send_codon(BASE_A, BASE_T, BASE_G, 1'b0);
        send_codon(BASE_T, BASE_A, BASE_A, 1'b0);
        send_codon(BASE_T, BASE_T, BASE_T, 1'b1);

        // A longer sequence: both the closed ORF and the wrap candidate fall short.
        send_codon(BASE_A, BASE_T, BASE_G, 1'b0);
        repeat (LONG_FILL) send_codon(BASE_C, BASE_C, BASE_C, 1'b0);
        send_codon(BASE_T, BASE_A, BASE_A, 1'b0);
        send_codon(BASE_A, BASE_T, BASE_G, 1'b0);
        send_codon(BASE_T, BASE_T, BASE_T, 1'b1);
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            case ($urandom_range(0, 7))
                0: write_reg(REG_MIN_CODONS, 16'd0);
                1: write_reg(REG_MIN_CODONS, 16'hFFFF);
                2: write_reg(REG_MIN_CODONS, 16'($urandom));
                default: write_reg(REG_MIN_CODONS, 16'($urandom_range(1, 6)));
            endcase
            write_reg(REG_CIRCULAR, 16'($urandom_range(0, 1)));
            send_gaps = (ph < 7) && (ph != 1) && ($urandom_range(0, 3) != 0);
            recv_gaps = (ph < 7) && ($urandom_range(0, 3) != 0);
            if (ph == 1) begin
                hold_req = 1'b1;
            end
            sent = 0;
            while (sent < 120) begin
                len = $urandom_range(1, 40);
                send_run(len, $urandom_range(0, 6) == 0);
                sent += len;
            end
            settle();
        end

        if (orfs.errors == 0 && orfs.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/orff_pkg.sv
src/orff_front.sv
src/orff_queue.sv
src/orff_back.sv
src/open_reading_frame_finder_unit.sv
tb/open_reading_frame_finder_unit_tb.sv
